// ----- rtl/core/lgss_pkg.sv -----
// ----------------------------------------------------------------------------
// lgss_pkg
// Types and constants shared by the linear gradient span shader.
// ----------------------------------------------------------------------------
package lgss_pkg;

  // longest span shaded; longer requests are cut to this many pixels
  localparam int unsigned MaxSpan = 64;

  // fixed point of the gradient parameter: 1.0 = 2^17
  localparam int unsigned FracBits = 17;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_SCALE      = 3'd0,
    REG_Y_SCALE      = 3'd1,
    REG_PARAM_OFFSET = 3'd2,
    REG_COLOR_START  = 3'd3,
    REG_COLOR_END    = 3'd4,
    REG_OPACITY      = 3'd5,
    REG_WRAP_MODE    = 3'd6
  } reg_index_t;

  // tile modes; the fourth code behaves as mirror
  typedef enum logic [1:0] {
    TILE_CLAMP  = 2'd0,
    TILE_REPEAT = 2'd1,
    TILE_MIRROR = 2'd2
  } wrap_mode_t;

  typedef struct packed {
    logic [13:0] start_x;
    logic [13:0] row_y;
    logic [6:0]  span_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/core/linear_gradient_span_shader.sv -----
// ----------------------------------------------------------------------------
// linear_gradient_span_shader
// Shades a span of pixels from a linear gradient with clamp, repeat or
// mirror tiling, giving premultiplied ARGB8888 pixels.
// ----------------------------------------------------------------------------
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data          | span request item
//  out     | out_valid, out_ready, out_data       | one pixel item, last flag
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write
//
//  The request for a span of n pixels (n cut to 64) is taken first; then
//  the sequencer issues one pixel a cycle, unless out is stalled, into an
//  8-stage pipeline.
//  A new span is taken in the cycle after the last pixel is issued; an
//  empty span gives no pixel.
//  Reset is synchronous; it clears valid bits and the registers to defaults.
//  When out is stalled with a pixel waiting, the whole pipeline holds.
// ----------------------------------------------------------------------------
module linear_gradient_span_shader (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lgss_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lgss_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int unsigned NumStages = 8;
  localparam logic [17:0] TOne = 18'(1) << lgss_pkg::FracBits;

  // configuration registers
  logic signed [31:0] x_scale, y_scale, param_offset;
  logic [63:0]        color_start, color_end;
  logic [12:0]        opacity;
  logic [1:0]         wrap_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale      <= '0;
      y_scale      <= '0;
      param_offset <= '0;
      color_start  <= '0;
      color_end    <= '0;
      opacity      <= 13'd4096;
      wrap_mode    <= lgss_pkg::TILE_CLAMP;
    end else if (cfg_valid) begin
      case (cfg_index)
        lgss_pkg::REG_X_SCALE:      x_scale      <= cfg_data[31:0];
        lgss_pkg::REG_Y_SCALE:      y_scale      <= cfg_data[31:0];
        lgss_pkg::REG_PARAM_OFFSET: param_offset <= cfg_data[31:0];
        lgss_pkg::REG_COLOR_START:  color_start  <= cfg_data;
        lgss_pkg::REG_COLOR_END:    color_end    <= cfg_data;
        lgss_pkg::REG_OPACITY:      opacity      <= cfg_data[12:0];
        lgss_pkg::REG_WRAP_MODE:    wrap_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the output item is held
  logic [NumStages-1:0] vld;
  logic                 ce;
  assign ce = !vld[NumStages-1] || out_ready;

  // span sequencer
  logic        busy;
  logic [6:0]  remaining;
  logic [14:0] cur_x;
  logic [14:0] ycoord;
  logic [6:0]  span_sat;

  assign in_ready = !busy;
  assign span_sat = (in_data.span_count > 7'(lgss_pkg::MaxSpan))
                    ? 7'(lgss_pkg::MaxSpan) : in_data.span_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (in_valid && !busy) begin
      busy      <= (span_sat != 7'd0);
      remaining <= span_sat;
    end else if (busy && ce) begin
      busy      <= (remaining != 7'd1);
      remaining <= remaining - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !busy) begin
      cur_x  <= {1'b0, in_data.start_x};
      ycoord <= {in_data.row_y, 1'b1};
    end else if (busy && ce) begin
      cur_x <= cur_x + 15'd1;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NumStages-2:0], busy};
    end
  end

  logic [NumStages-2:0] last_p;
  always_ff @(posedge clk) begin
    if (ce) begin
      last_p <= {last_p[NumStages-3:0], (remaining == 7'd1)};
    end
  end

  // stage 0: doubled pixel centres
  logic [15:0] s0_xc;
  logic [14:0] s0_yc;
  always_ff @(posedge clk) begin
    if (ce) begin
      s0_xc <= {cur_x, 1'b1};
      s0_yc <= ycoord;
    end
  end

  // stage 1: scale products
  logic signed [48:0] s1_px;
  logic signed [47:0] s1_py;
  always_ff @(posedge clk) begin
    if (ce) begin
      s1_px <= x_scale * $signed({1'b0, s0_xc});
      s1_py <= y_scale * $signed({1'b0, s0_yc});
    end
  end

  // stage 2: gradient parameter, Q.17
  logic signed [50:0] s2_w;
  always_ff @(posedge clk) begin
    if (ce) begin
      s2_w <= 51'(s1_px) + 51'(s1_py) + 51'($signed({param_offset, 1'b0}));
    end
  end

  // stage 3: tiling
  logic [17:0] t_next, s3_t, mir;
  always_comb begin
    mir = s2_w[17:0];
    case (wrap_mode)
      lgss_pkg::TILE_CLAMP: begin
        if (s2_w[50])                     t_next = '0;
        else if (s2_w > 51'sd131072)      t_next = TOne;
        else                              t_next = s2_w[17:0];
      end
      lgss_pkg::TILE_REPEAT: t_next = {1'b0, s2_w[16:0]};
      default: t_next = (mir >= TOne) ? (18'(2) * TOne - mir) : mir;
    endcase
  end
  always_ff @(posedge clk) begin
    if (ce) s3_t <= t_next;
  end

  // stage 4: per-channel interpolation, Q.16
  logic [19:0] s4_c [4];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        s4_c[k] <= 20'((34'(color_start[16*k +: 16]) * 34'(TOne - s3_t)
                      + 34'(color_end[16*k +: 16]) * 34'(s3_t)) >> 13);
      end
    end
  end

  // stage 5: alpha times opacity, Q.28
  logic [32:0] s5_ao;
  logic [19:0] s5_c [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      s5_ao <= 33'(s4_c[3]) * 33'(opacity);
      for (int k = 0; k < 3; k++) s5_c[k] <= s4_c[k];
    end
  end

  // stage 6: colour premultiply (Q.44) and alpha byte
  logic [52:0] s6_p [3];
  logic [7:0]  s6_a;
  logic [28:0] a_clamped;
  logic [36:0] a_scaled;
  always_comb begin
    a_clamped = (s5_ao > 33'h10000000) ? 29'h10000000 : s5_ao[28:0];
    a_scaled  = {a_clamped, 8'd0} - 37'(a_clamped);
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) s6_p[k] <= 53'(s5_c[k]) * 53'(s5_ao);
      s6_a <= a_scaled[35:28];
    end
  end

  // stage 7: clamp and scale colour bytes
  logic [44:0] c_clamped [3];
  logic [52:0] c_scaled  [3];
  logic [7:0]  c_byte    [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_clamped[k] = (s6_p[k] > 53'h100000000000) ? 45'h100000000000 : s6_p[k][44:0];
      c_scaled[k]  = {c_clamped[k], 8'd0} - 53'(c_clamped[k]);
      c_byte[k]    = c_scaled[k][51:44];
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      out_data.pixel <= {s6_a, c_byte[2], c_byte[1], c_byte[0]};
      out_data.last  <= last_p[NumStages-2];
    end
  end

  assign out_valid = vld[NumStages-1];

  // checks
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> remaining != 7'd0)
    else $error("sequencer busy with nothing left");

  a_empty_span: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.span_count == 7'd0) |=> !busy)
    else $error("empty span started the sequencer");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && ce && remaining == 7'd1) |=> !busy)
    else $error("sequencer kept running after the last pixel");

endmodule

// ----- dv/linear_gradient_span_shader_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_gradient_span_shader_tb
// Drives span requests through the shader with random idling on both sides,
// predicts every pixel from an independent model of the gradient arithmetic
// and checks each returned pixel and its last flag in order.
// ----------------------------------------------------------------------------
module linear_gradient_span_shader_tb;

  localparam int unsigned WatchdogLimit = 20000;
  localparam longint unsigned TOne = 64'd1 << 17;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  lgss_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lgss_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  linear_gradient_span_shader dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the shader registers
  logic signed [31:0] sh_x_scale;
  logic signed [31:0] sh_y_scale;
  logic signed [31:0] sh_offset;
  logic [63:0] sh_col_start;
  logic [63:0] sh_col_end;
  logic [12:0] sh_opacity;
  logic [1:0] sh_tile;

  lgss_pkg::in_item_t span_queue[$];
  lgss_pkg::out_item_t pixel_queue[$];
  int unsigned error_count = 0;
  int unsigned idle_count = 0;
  bit stim_done = 1'b0;
  bit run_over = 1'b0;

  // gradient parameter folded into [0, 1.0] by the tile mode
  function automatic longint unsigned fold_param(longint signed w);
    longint unsigned m;
    if (sh_tile == lgss_pkg::TILE_CLAMP) begin
      if (w < 0) return 0;
      if (w > longint'(TOne)) return TOne;
      return longint'(w);
    end
    if (sh_tile == lgss_pkg::TILE_REPEAT) return longint'(w) & (TOne - 1);
    m = longint'(w) & ((TOne << 1) - 1);
    if (m >= TOne) m = (TOne << 1) - m;
    return m;
  endfunction

  function automatic longint unsigned mix_channel(int sh, longint unsigned t);
    longint unsigned a;
    longint unsigned b;
    a = (sh_col_start >> sh) & 64'hFFFF;
    b = (sh_col_end >> sh) & 64'hFFFF;
    return (a * (TOne - t) + b * t) >> 13;
  endfunction

  function automatic logic [7:0] sat_byte(longint unsigned v, int ob);
    longint unsigned one;
    one = 64'd1 << ob;
    if (v > one) v = one;
    return 8'((v * 255) >> ob);
  endfunction

  function automatic logic [31:0] shade_pixel(longint unsigned t);
    longint unsigned ao;
    ao = mix_channel(48, t) * longint'(sh_opacity);
    return {sat_byte(ao, 28), sat_byte(mix_channel(32, t) * ao, 44),
            sat_byte(mix_channel(16, t) * ao, 44), sat_byte(mix_channel(0, t) * ao, 44)};
  endfunction

  // expected pixels of one accepted span
  task automatic predict_span(lgss_pkg::in_item_t s);
    longint signed base;
    longint signed w;
    int n;
    lgss_pkg::out_item_t p;
    n = int'((s.span_count > 7'(lgss_pkg::MaxSpan)) ? 7'(lgss_pkg::MaxSpan)
                                                     : s.span_count);
    base = longint'(sh_y_scale) * (2 * longint'(s.row_y) + 1) + 2 * longint'(sh_offset);
    for (int i = 0; i < n; i++) begin
      w = base + longint'(sh_x_scale) * (2 * (longint'(s.start_x) + i) + 1);
      p.pixel = shade_pixel(fold_param(w));
      p.last = (i == n - 1);
      pixel_queue.push_back(p);
    end
  endtask

  // span driver
  int unsigned in_gap = 0;
  bit hold_off = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_span(in_data);
        in_gap <= $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else if (!in_valid && !hold_off) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (span_queue.size() > 0) begin
          in_data <= span_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // pixel monitor with random stall
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected pixel %h last %b", out_data.pixel, out_data.last);
          error_count++;
        end else begin
          if (out_data.pixel !== pixel_queue[0].pixel) begin
            $error("pixel: expected %h actual %h", pixel_queue[0].pixel, out_data.pixel);
            error_count++;
          end
          if (out_data.last !== pixel_queue[0].last) begin
            $error("last: expected %b actual %b", pixel_queue[0].last, out_data.last);
            error_count++;
          end
          void'(pixel_queue.pop_front());
        end
        out_gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
        out_ready <= (out_gap == 0);
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= (out_gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst && !run_over) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
          || (stim_done && pixel_queue.size() == 0 && span_queue.size() == 0)) begin
        idle_count <= 0;
      end else if (idle_count >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  task automatic write_reg(lgss_pkg::reg_index_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lgss_pkg::REG_X_SCALE: sh_x_scale = val[31:0];
      lgss_pkg::REG_Y_SCALE: sh_y_scale = val[31:0];
      lgss_pkg::REG_PARAM_OFFSET: sh_offset = val[31:0];
      lgss_pkg::REG_COLOR_START: sh_col_start = val;
      lgss_pkg::REG_COLOR_END: sh_col_end = val;
      lgss_pkg::REG_OPACITY: sh_opacity = val[12:0];
      lgss_pkg::REG_WRAP_MODE: sh_tile = val[1:0];
      default: ;
    endcase
  endtask

  // wait until all spans are sent and every pixel back, then let the pipe drain;
  // checked at the falling edge so that the driver's updates have settled
  task automatic drain();
    while (span_queue.size() > 0 || in_valid || pixel_queue.size() > 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic add_span(int x, int y, int n);
    lgss_pkg::in_item_t s;
    s.start_x = 14'(x);
    s.row_y = 14'(y);
    s.span_count = 7'(n);
    span_queue.push_back(s);
  endtask

  function automatic logic [63:0] rand_colour(bit over);
    logic [63:0] c;
    for (int k = 0; k < 4; k++)
      c[k*16 +: 16] = over ? 16'($urandom) : 16'($urandom_range(0, 4096));
    return c;
  endfunction

  task automatic rand_config(int phase);
    logic [31:0] xs;
    int sel;
    sel = $urandom_range(0, 3);
    xs = (sel == 0) ? $urandom : (sel == 1) ? 32'($urandom_range(0, 8192)) - 4096
       : (sel == 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    write_reg(lgss_pkg::REG_X_SCALE, {32'h0, xs});
    write_reg(lgss_pkg::REG_Y_SCALE, {32'h0, ($urandom_range(0, 1)) ? $urandom
                                   : 32'($urandom_range(0, 4096)) - 2048});
    write_reg(lgss_pkg::REG_PARAM_OFFSET, {32'h0, $urandom});
    write_reg(lgss_pkg::REG_COLOR_START, rand_colour(phase % 5 == 4));
    write_reg(lgss_pkg::REG_COLOR_END, rand_colour(phase % 7 == 6));
    write_reg(lgss_pkg::REG_OPACITY, (phase % 3 == 0) ? 64'd4096 : (phase % 3 == 1)
                           ? 64'($urandom_range(0, 4096)) : 64'($urandom_range(0, 8191)));
    write_reg(lgss_pkg::REG_WRAP_MODE, 64'(phase % 4));
  endtask

  initial begin
    sh_x_scale = '0; sh_y_scale = '0; sh_offset = '0;
    sh_col_start = '0; sh_col_end = '0; sh_opacity = 13'd4096;
    sh_tile = lgss_pkg::TILE_CLAMP;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset defaults, then field extremes in every tile mode
    add_span(0, 0, 1);
    drain();
    write_reg(lgss_pkg::REG_COLOR_START, 64'h1000_1000_0000_0800);
    write_reg(lgss_pkg::REG_COLOR_END, 64'h1000_0000_1000_0400);
    write_reg(lgss_pkg::REG_X_SCALE, 64'h0000_0800);
    write_reg(lgss_pkg::REG_Y_SCALE, 64'hFFFF_F000);
    write_reg(lgss_pkg::REG_PARAM_OFFSET, 64'hFFFF_0000);
    write_reg(lgss_pkg::REG_OPACITY, 64'd4096);
    for (int m = 0; m < 4; m++) begin
      write_reg(lgss_pkg::REG_WRAP_MODE, 64'(m));
      add_span(0, 0, 64);
      add_span(16383, 16383, 1);
      add_span(16380, 3, 127);
      add_span(100, 200, 0);
      add_span(5, 9, 65);
      drain();
    end
    write_reg(lgss_pkg::REG_COLOR_START, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(lgss_pkg::REG_OPACITY, 64'd8191);
    write_reg(lgss_pkg::REG_X_SCALE, 64'h8000_0000);
    add_span(8191, 8192, 64);
    drain();
    write_reg(lgss_pkg::REG_X_SCALE, 64'h7FFF_FFFF);
    add_span(16383, 0, 64);
    drain();
    write_reg(lgss_pkg::REG_OPACITY, 64'd0);
    add_span(1, 1, 3);
    drain();

    // random phases; each ends idle before the registers change
    for (int ph = 0; ph < 20; ph++) begin
      rand_config(ph);
      for (int j = 0; j < 18; j++) begin
        if ($urandom_range(0, 9) == 0) add_span($urandom, $urandom, $urandom_range(0, 127));
        else add_span($urandom_range(0, 16383), $urandom_range(0, 16383),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 8));
        if (j == 9 && ph == 3) begin
          // sender holds until all pixels are back
          while (span_queue.size() > 0 || in_valid) @(negedge clk);
          hold_off <= 1'b1;
          while (pixel_queue.size() > 0) @(negedge clk);
          hold_off <= 1'b0;
        end
      end
      drain();
    end
    stim_done = 1'b1;
    run_over = 1'b1;
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- linear_gradient_span_shader.f -----
rtl/core/lgss_pkg.sv
rtl/core/linear_gradient_span_shader.sv
dv/linear_gradient_span_shader_tb.sv
